### hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 11;

    // operation codes on the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // command broadcast along the row of cells
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_PUSH_F = 3'd1,
        OP_PUSH_B = 3'd2,
        OP_POP_F  = 3'd3,
        OP_POP_B  = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  value;
    } cmd_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                      occ;
        logic signed [WORD_W-1:0]  f;
        logic signed [WORD_W-1:0]  m;
    } link_t;

    // fixed taps at both ends of the row
    typedef struct packed {
        logic                      occ0;
        logic                      occ1;
        logic                      occ_last;
        logic signed [WORD_W-1:0]  f0;
        logic signed [WORD_W-1:0]  f1;
        logic signed [WORD_W-1:0]  m0;
        logic signed [WORD_W-1:0]  m1;
    } taps_t;

endpackage

### hw/rtl/deq_cell.sv
module deq_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  deq_pkg::cmd_t  cmd,
    input  deq_pkg::link_t left,
    input  deq_pkg::link_t right,
    output deq_pkg::link_t cur
);

    logic                              occ_reg;
    logic                              occ_next;
    logic signed [deq_pkg::WORD_W-1:0] f_reg;
    logic signed [deq_pkg::WORD_W-1:0] f_next;
    logic signed [deq_pkg::WORD_W-1:0] m_reg;
    logic signed [deq_pkg::WORD_W-1:0] m_next;
    logic                              first_free;

    assign cur.occ = occ_reg;
    assign cur.f   = f_reg;
    assign cur.m   = m_reg;

    // first empty cell: takes the word at the far end of the other chain
    assign first_free = left.occ && !occ_reg;

    always_comb
    begin
        occ_next = occ_reg;
        f_next   = f_reg;
        m_next   = m_reg;
        case (cmd.op)
            deq_pkg::OP_PUSH_F:
            begin
                occ_next = left.occ;
                f_next   = left.f;
                if (first_free)
                begin
                    m_next = cmd.value;
                end
            end
            deq_pkg::OP_PUSH_B:
            begin
                occ_next = left.occ;
                m_next   = left.m;
                if (first_free)
                begin
                    f_next = cmd.value;
                end
            end
            deq_pkg::OP_POP_F:
            begin
                occ_next = right.occ;
                f_next   = right.f;
            end
            deq_pkg::OP_POP_B:
            begin
                occ_next = right.occ;
                m_next   = right.m;
            end
            deq_pkg::OP_CLEAR:
            begin
                occ_next = 1'b0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        m_reg <= m_next;
    end

endmodule

### hw/rtl/deq_chain.sv
module deq_chain #(
    parameter int DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  deq_pkg::cmd_t  cmd,
    output deq_pkg::taps_t taps
);

    deq_pkg::link_t cells [DEPTH];
    deq_pkg::link_t head;
    deq_pkg::link_t tail;

    // left of cell 0 sits the incoming word, right of the last cell nothing
    assign head.occ = 1'b1;
    assign head.f   = cmd.value;
    assign head.m   = cmd.value;
    assign tail.occ = 1'b0;
    assign tail.f   = '0;
    assign tail.m   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        deq_pkg::link_t left_in;
        deq_pkg::link_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = head;
        end
        else
        begin : g_left
            assign left_in = cells[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = tail;
        end
        else
        begin : g_right
            assign right_in = cells[i+1];
        end

        deq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_in),
            .right (right_in),
            .cur   (cells[i])
        );
    end

    assign taps.occ0     = cells[0].occ;
    assign taps.occ1     = cells[1].occ;
    assign taps.occ_last = cells[DEPTH-1].occ;
    assign taps.f0       = cells[0].f;
    assign taps.f1       = cells[1].f;
    assign taps.m0       = cells[0].m;
    assign taps.m1       = cells[1].m;

endmodule

### hw/rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, DEPTH words deep. Each
// input word carries one operation (push front, push back, pop front, pop
// back, clear; other kind codes do nothing) and gives exactly one result word
// with the popped value, a status (ok, pop on empty, push on full), the count
// and empty flag after the operation and the front and back words (zero when
// empty). Storage is a row of DEPTH identical cells; each cell holds one word
// of a front-ordered chain, one word of a back-ordered chain and an occupied
// bit, and every push or pop is a one-step shift of the row, so the front word
// always sits in cell 0 of the first chain and the back word in cell 0 of the
// second. A new word is accepted every cycle unless in_stall is raised, and the
// result appears in the output register on the next cycle; in_stall is raised
// only while that register holds a result that out_stall keeps from leaving.
// Reset clears count and occupied bits at once; no clearing pass is needed.
module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [deq_pkg::KIND_W-1:0]          kind,
    input  logic signed [deq_pkg::WORD_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [deq_pkg::WORD_W-1:0]   popped,
    output logic [1:0]                          status,
    output logic [deq_pkg::COUNT_W-1:0]         count,
    output logic                                empty_res,
    output logic signed [deq_pkg::WORD_W-1:0]   front_word,
    output logic signed [deq_pkg::WORD_W-1:0]   back_word
);

    localparam int CW = $clog2(DEPTH + 1);

    // handshake
    logic accept;

    // queue occupancy
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // row of cells
    deq_pkg::cmd_t  cmd;
    deq_pkg::op_t   op;
    deq_pkg::taps_t taps;

    // result of the word being accepted
    logic signed [deq_pkg::WORD_W-1:0] res_popped;
    deq_pkg::status_t                  res_status;
    logic signed [deq_pkg::WORD_W-1:0] res_front;
    logic signed [deq_pkg::WORD_W-1:0] res_back;

    // output register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [deq_pkg::WORD_W-1:0] popped_reg;
    logic [1:0]                        status_reg;
    logic [deq_pkg::COUNT_W-1:0]       count_out_reg;
    logic                              empty_reg;
    logic signed [deq_pkg::WORD_W-1:0] front_reg;
    logic signed [deq_pkg::WORD_W-1:0] back_reg;

    // hold off the source only while a finished result cannot leave
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // decode: pick the row operation and work out the result from the end taps
    always_comb
    begin
        op         = deq_pkg::OP_NONE;
        count_next = count_reg;
        res_popped = '0;
        res_status = deq_pkg::ST_OK;
        // unchanged queue by default (also covers pop on empty: all zero)
        res_front  = taps.occ0 ? taps.f0 : '0;
        res_back   = taps.occ0 ? taps.m0 : '0;
        case (kind)
            deq_pkg::KIND_PUSH_FRONT:
            begin
                if (taps.occ_last)
                begin
                    res_status = deq_pkg::ST_FULL;
                end
                else
                begin
                    op         = deq_pkg::OP_PUSH_F;
                    count_next = count_reg + CW'(1);
                    res_front  = value;
                    res_back   = taps.occ0 ? taps.m0 : value;
                end
            end
            deq_pkg::KIND_PUSH_BACK:
            begin
                if (taps.occ_last)
                begin
                    res_status = deq_pkg::ST_FULL;
                end
                else
                begin
                    op         = deq_pkg::OP_PUSH_B;
                    count_next = count_reg + CW'(1);
                    res_back   = value;
                    res_front  = taps.occ0 ? taps.f0 : value;
                end
            end
            deq_pkg::KIND_POP_FRONT:
            begin
                if (!taps.occ0)
                begin
                    res_status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    op         = deq_pkg::OP_POP_F;
                    count_next = count_reg - CW'(1);
                    res_popped = taps.f0;
                    res_front  = taps.occ1 ? taps.f1 : '0;
                    res_back   = taps.occ1 ? taps.m0 : '0;
                end
            end
            deq_pkg::KIND_POP_BACK:
            begin
                if (!taps.occ0)
                begin
                    res_status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    op         = deq_pkg::OP_POP_B;
                    count_next = count_reg - CW'(1);
                    res_popped = taps.m0;
                    res_back   = taps.occ1 ? taps.m1 : '0;
                    res_front  = taps.occ1 ? taps.f0 : '0;
                end
            end
            deq_pkg::KIND_CLEAR:
            begin
                op         = deq_pkg::OP_CLEAR;
                count_next = '0;
                res_front  = '0;
                res_back   = '0;
            end
            default:
            begin
                op = deq_pkg::OP_NONE;
            end
        endcase
    end

    // the row only moves on an accepted word
    assign cmd.op    = accept ? op : deq_pkg::OP_NONE;
    assign cmd.value = value;

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .taps  (taps)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg    <= res_popped;
            status_reg    <= res_status;
            count_out_reg <= deq_pkg::COUNT_W'(count_next);
            empty_reg     <= (count_next == '0);
            front_reg     <= res_front;
            back_reg      <= res_back;
        end
    end

    assign popped     = popped_reg;
    assign status     = status_reg;
    assign count      = count_out_reg;
    assign empty_res  = empty_reg;
    assign front_word = front_reg;
    assign back_word  = back_reg;

    // occupied bit of cell 0 tracks a non-empty queue
    a_occ0_count: assert property (@(posedge clk) disable iff (!rst_n)
        taps.occ0 == (count_reg != '0))
        else $error("cell 0 occupancy disagrees with count");

    // occupied bit of the last cell tracks a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        taps.occ_last == (count_reg == CW'(DEPTH)))
        else $error("last cell occupancy disagrees with count");

    // an accepted word always leaves a result waiting
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    // a stalled result blocks the row from moving
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(count_reg))
        else $error("queue changed while input was stalled");

endmodule
